// File: rtl/core/hne_pkg.sv
// Package for the heightmap normal engine: state encoding, register indexes,
// stream widths and the pixel normalisation table.
// Has no dependencies; imported by heightmap_normal_engine and its testbench.
`default_nettype none

package hne_pkg;

  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 112;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH,
    CFG_DEPTH,
    CFG_OFFSET,
    CFG_SCALE
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WSUM,
    ST_WMUL,
    ST_WRND,
    ST_WUPD,
    ST_QRD,
    ST_QDIF,
    ST_QSQX,
    ST_QSQZ,
    ST_QSUM,
    ST_QSQRT,
    ST_QDINIT,
    ST_QDIV,
    ST_QDFIN,
    ST_DONE
  } st_e;

  // Pixel byte to pixel/127.5 - 1 in signed Q2.16, rounded.
  typedef logic signed [17:0] norm_lut_t [256];

  function automatic norm_lut_t build_norm_lut();
    norm_lut_t l;
    for (int p = 0; p < 256; p++) begin
      l[p] = 18'((p * 262144 + 255) / 510 - 65536);
    end
    return l;
  endfunction

  localparam norm_lut_t NORM_LUT = build_norm_lut();

endpackage

`default_nettype wire

// File: rtl/core/heightmap_normal_engine.sv
// Heightmap normal engine: a write request passes through the sum, multiply,
// round and update states; a query request passes through a 32-step square root
// and three 16-step restoring divisions. Queries read their four neighbours
// through the single port of the height memory. A new request is accepted
// once the previous one has passed into the output register, so the block
// takes no new request while one is still in progress.
// Reset clears the control state, min/max and configuration; the height
// memory is not cleared.
`default_nettype none

module heightmap_normal_engine #(
  parameter int MAX_COLS = hne_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = hne_pkg::MAX_ROWS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // col [7:0], row [15:8], pixel [23:16]
  input  wire logic [hne_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  wire logic                            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // stored_height [31:0], height_span [62:32], normal_x [78:63],
  // normal_y [93:79], normal_z [109:94], zero [111:110]
  output logic [hne_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [hne_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i
);
  import hne_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int XW = (CW > 9) ? CW : 9;
  localparam int YW = (RW > 9) ? RW : 9;

  st_e state_q, state_d;

  logic [8:0]         width_q, depth_q;
  logic signed [31:0] offset_q, scale_q;
  logic signed [31:0] min_q, max_q;

  logic               kind_q;
  logic [7:0]         col_q, row_q, pixel_q;

  logic signed [32:0] sum_q;
  logic signed [64:0] prod_q;
  logic signed [31:0] h_q;

  logic [2:0]         cnt_q;
  logic signed [31:0] nb_q [4];
  logic signed [31:0] rdata_q;
  logic signed [31:0] mem [2**AW];

  logic [30:0]        ax_q, az_q;
  logic               sx_q, sz_q, big_q;
  logic [61:0]        mul_q;
  logic [63:0]        acc_q, res_q;
  logic [4:0]         it_q;
  logic [31:0]        m_q;
  logic [1:0]         cm_q;
  logic [3:0]         dk_q;
  logic [33:0]        rem_q;
  logic [15:0]        lo_q, quo_q;
  logic [15:0]        nx_q, nz_q;
  logic [14:0]        ny_q;

  logic               out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // Control strobes.
  logic               mem_we, mem_re, out_load, in_take;
  logic [AW-1:0]      mem_addr;

  // Effective grid size and clamped query point.
  logic [8:0] w_eff, d_eff, qx, qz, nbx, nbz;
  logic [XW-1:0] ax_ext;
  logic [YW-1:0] az_ext;

  always_comb begin
    if (width_q < 9'd3) w_eff = 9'd3;
    else if ({23'd0, width_q} > MAX_COLS) w_eff = 9'(MAX_COLS);
    else w_eff = width_q;
    if (depth_q < 9'd3) d_eff = 9'd3;
    else if ({23'd0, depth_q} > MAX_ROWS) d_eff = 9'(MAX_ROWS);
    else d_eff = depth_q;
    qx = (col_q == 8'd0) ? 9'd1 : {1'b0, col_q};
    qz = (row_q == 8'd0) ? 9'd1 : {1'b0, row_q};
    if (qx > w_eff - 9'd2) qx = w_eff - 9'd2;
    if (qz > d_eff - 9'd2) qz = d_eff - 9'd2;
    case (cnt_q)
      3'd0:    begin nbx = qx - 9'd1; nbz = qz;        end
      3'd1:    begin nbx = qx + 9'd1; nbz = qz;        end
      3'd2:    begin nbx = qx;        nbz = qz - 9'd1; end
      default: begin nbx = qx;        nbz = qz + 9'd1; end
    endcase
    if (state_q == ST_QRD) begin
      ax_ext = XW'(nbx);
      az_ext = YW'(nbz);
    end else begin
      ax_ext = XW'(col_q);
      az_ext = YW'(row_q);
    end
    mem_addr = {az_ext[RW-1:0], ax_ext[CW-1:0]};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid_i) state_d = s_axis_tuser_i ? ST_QRD : ST_WSUM;
      ST_WSUM:   state_d = ST_WMUL;
      ST_WMUL:   state_d = ST_WRND;
      ST_WRND:   state_d = ST_WUPD;
      ST_WUPD:   state_d = ST_DONE;
      ST_QRD:    if (cnt_q == 3'd4) state_d = ST_QDIF;
      ST_QDIF:   state_d = ST_QSQX;
      ST_QSQX:   state_d = ST_QSQZ;
      ST_QSQZ:   state_d = ST_QSUM;
      ST_QSUM:   state_d = ST_QSQRT;
      ST_QSQRT:  if (it_q == 5'd31) state_d = ST_QDINIT;
      ST_QDINIT: state_d = ST_QDIV;
      ST_QDIV:   if (dk_q == 4'd15) state_d = ST_QDFIN;
      ST_QDFIN:  state_d = (cm_q == 2'd2) ? ST_DONE : ST_QDINIT;
      ST_DONE:   if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Strobes.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    in_take         = s_axis_tready_o && s_axis_tvalid_i;
    mem_re          = (state_q == ST_QRD) && (cnt_q != 3'd4);
    mem_we          = (state_q == ST_WUPD) && ({1'b0, col_q} < w_eff)
                      && ({1'b0, row_q} < d_eff);
    out_load        = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);
    cfg_ready_o     = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= h_q;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  // Combinational helpers for the datapath.
  logic signed [64:0] rnd;
  logic signed [31:0] h_sat;
  logic signed [32:0] dx, dz;
  logic [32:0]        mx, mz;
  logic               big;
  logic [63:0]        sq_bit, sq_try;
  logic [30:0]        mag_sel;
  logic [33:0]        div_t, div_d;
  logic               neg_sel;
  logic [15:0]        comp;
  logic [32:0]        span_full;
  logic [30:0]        span;

  always_comb begin
    rnd = (prod_q + 65'sd32768) >>> 16;
    if (rnd > 65'sd2147483647) h_sat = 32'sh7FFFFFFF;
    else if (rnd < -65'sd2147483648) h_sat = 32'sh80000000;
    else h_sat = 32'(rnd);

    dx  = 33'(nb_q[0]) - 33'(nb_q[1]);
    dz  = 33'(nb_q[3]) - 33'(nb_q[2]);
    mx  = dx[32] ? 33'(-dx) : 33'(dx);
    mz  = dz[32] ? 33'(-dz) : 33'(dz);
    big = mx[32] | mx[31] | mz[32] | mz[31];

    sq_bit = 64'd1 << (6'd62 - {it_q, 1'b0});
    sq_try = res_q + sq_bit;

    case (cm_q)
      2'd0:    begin mag_sel = ax_q; neg_sel = sx_q; end
      2'd1:    begin mag_sel = big_q ? 31'd65536 : 31'd131072; neg_sel = 1'b0; end
      default: begin mag_sel = az_q; neg_sel = sz_q; end
    endcase
    div_t = {rem_q[32:0], lo_q[15]};
    div_d = {1'b0, m_q, 1'b0};
    if (neg_sel) comp = -quo_q;
    else if (quo_q > 16'd32767) comp = 16'd32767;
    else comp = quo_q;

    span_full = 33'(max_q) - 33'(min_q);
    span = (span_full > 33'h07FFFFFFF) ? 31'h7FFFFFFF : span_full[30:0];
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= 9'd256;
      depth_q     <= 9'd256;
      offset_q    <= '0;
      scale_q     <= 32'sd65536;
      min_q       <= '0;
      max_q       <= '0;
      cnt_q       <= '0;
      it_q        <= '0;
      cm_q        <= '0;
      dk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_WIDTH:  width_q  <= cfg_data_i[8:0];
          CFG_DEPTH:  depth_q  <= cfg_data_i[8:0];
          CFG_OFFSET: offset_q <= cfg_data_i;
          CFG_SCALE:  scale_q  <= cfg_data_i;
          default:    ;
        endcase
      end
      if (mem_we) begin
        if (h_q < min_q) min_q <= h_q;
        if (h_q > max_q) max_q <= h_q;
      end
      if (in_take) cnt_q <= '0;
      else if (state_q == ST_QRD) cnt_q <= cnt_q + 3'd1;
      if (state_q == ST_QSUM) it_q <= '0;
      else if (state_q == ST_QSQRT) it_q <= it_q + 5'd1;
      if (in_take) cm_q <= '0;
      else if (state_q == ST_QDFIN) cm_q <= cm_q + 2'd1;
      if (state_q == ST_QDINIT) dk_q <= '0;
      else if (state_q == ST_QDIV) dk_q <= dk_q + 4'd1;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q  <= s_axis_tuser_i;
      col_q   <= s_axis_tdata_i[7:0];
      row_q   <= s_axis_tdata_i[15:8];
      pixel_q <= s_axis_tdata_i[23:16];
      h_q     <= '0;
      nx_q    <= '0;
      ny_q    <= '0;
      nz_q    <= '0;
    end
    case (state_q)
      ST_WSUM: sum_q  <= 33'(NORM_LUT[pixel_q]) + 33'(offset_q);
      ST_WMUL: prod_q <= 65'(sum_q) * 65'(scale_q);
      ST_WRND: h_q    <= h_sat;
      ST_QRD:  if (cnt_q != 3'd0) nb_q[2'(cnt_q - 3'd1)] <= rdata_q;
      ST_QDIF: begin
        // Halve everything once if a difference does not fit in 31 bits.
        sx_q  <= dx[32];
        sz_q  <= dz[32];
        big_q <= big;
        ax_q  <= big ? mx[31:1] : mx[30:0];
        az_q  <= big ? mz[31:1] : mz[30:0];
      end
      ST_QSQX: mul_q <= 62'(ax_q) * 62'(az_q - az_q + ax_q);
      ST_QSQZ: begin
        acc_q <= (big_q ? 64'h1_0000_0000 : 64'h4_0000_0000) + 64'(mul_q);
        mul_q <= 62'(az_q) * 62'(az_q);
      end
      ST_QSUM: begin
        acc_q <= acc_q + 64'(mul_q);
        res_q <= '0;
      end
      ST_QSQRT: begin
        if (acc_q >= sq_try) begin
          acc_q <= acc_q - sq_try;
          res_q <= (res_q >> 1) + sq_bit;
        end else begin
          res_q <= res_q >> 1;
        end
        if (it_q == 5'd31) m_q <= (acc_q >= sq_try) ? 32'((res_q >> 1) + sq_bit)
                                                     : 32'(res_q >> 1);
      end
      ST_QDINIT: begin
        // The quotient fits 16 bits, so the top of the dividend is below 2m.
        rem_q <= 34'(mag_sel) + 34'(m_q[31:16]);
        lo_q  <= m_q[15:0];
        quo_q <= '0;
      end
      ST_QDIV: begin
        lo_q <= {lo_q[14:0], 1'b0};
        if (div_t >= div_d) begin
          rem_q <= div_t - div_d;
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= div_t;
          quo_q <= {quo_q[14:0], 1'b0};
        end
      end
      ST_QDFIN: begin
        case (cm_q)
          2'd0:    nx_q <= comp;
          2'd1:    ny_q <= comp[14:0];
          default: nz_q <= comp;
        endcase
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= {2'b00, nz_q, ny_q, nx_q, span, kind_q ? 32'd0 : h_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

// File: bench/tb_heightmap_normal_engine.sv
// Self-checking testbench for heightmap_normal_engine: height writes and normal
// queries are predicted in the bench and compared field by field with the results.
// Depends on hne_pkg and the heightmap_normal_engine RTL.
`timescale 1ns / 100ps

module tb_heightmap_normal_engine;
  import hne_pkg::*;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam int   CYCLE_LIMIT = 1000000;
  localparam int   QUERY_LATENCY = 120;

  typedef struct packed {
    logic       kind;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] pixel;
  } grid_req_t;

  // Members from the highest bit down, so height sits in the lowest bits.
  typedef struct packed {
    logic [15:0] nz;
    logic [14:0] ny;
    logic [15:0] nx;
    logic [30:0] span;
    logic [31:0] height;
  } grid_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  wire s_ready, m_valid, cfg_ready;
  wire [OUT_TDATA_W-1:0] m_tdata;

  heightmap_normal_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_tdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Bench-side copy of the block state.
  logic signed [31:0] model_store [0:65535];
  longint model_min = 0, model_max = 0;
  logic [8:0] model_width = 9'd256, model_depth = 9'd256;
  logic signed [31:0] model_offset = 0, model_scale = 32'sd65536;

  grid_rsp_t expected_rsp [$];
  grid_req_t pending_req [$];
  int mismatches = 0;
  int cycles = 0;
  bit burst_mode = 0;

  // Generation-side view of which cells hold a height.
  bit gen_written [0:65535];
  int gen_w = 256, gen_d = 256;

  function automatic int clamp_dim(logic [8:0] v);
    if (v < 3) return 3;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic logic signed [31:0] pixel_to_height(logic [7:0] pixel);
    longint norm, prod;
    norm = (longint'(pixel) * 262144 + 255) / 510 - 65536;
    prod = (norm + longint'(model_offset)) * longint'(model_scale);
    prod = (prod + 32768) >>> 16;
    if (prod > 64'sd2147483647) prod = 64'sd2147483647;
    if (prod < -64'sd2147483648) prod = -64'sd2147483648;
    return prod[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_component(logic [63:0] mag, bit neg, logic [63:0] m,
                                            longint lo);
    logic [63:0] q;
    longint r;
    q = (mag * 64'd65536 + m) / (64'd2 * m);
    r = neg ? -longint'(q) : longint'(q);
    if (r > 32767) r = 32767;
    if (r < lo) r = lo;
    return r;
  endfunction

  function automatic longint cell_height(int x, int z);
    return longint'(model_store[z * 256 + x]);
  endfunction

  // Updates the model for one accepted request and queues its result.
  task automatic predict_result(grid_req_t rq);
    grid_rsp_t rs;
    int w, d, x, z;
    longint h, dx, dz, span, nxo, nyo, nzo;
    logic [63:0] ax, ay, az, m;
    bit sx, sz;
    w = clamp_dim(model_width);
    d = clamp_dim(model_depth);
    h = 0; nxo = 0; nyo = 0; nzo = 0;
    if (rq.kind == KIND_WRITE) begin
      h = longint'(pixel_to_height(rq.pixel));
      if (rq.col < w && rq.row < d) begin
        model_store[int'(rq.row) * 256 + int'(rq.col)] = h[31:0];
        if (h < model_min) model_min = h;
        if (h > model_max) model_max = h;
      end
    end else begin
      x = int'(rq.col); z = int'(rq.row);
      if (x < 1) x = 1;
      if (z < 1) z = 1;
      if (x > w - 2) x = w - 2;
      if (z > d - 2) z = d - 2;
      dx = cell_height(x - 1, z) - cell_height(x + 1, z);
      dz = cell_height(x, z + 1) - cell_height(x, z - 1);
      sx = dx < 0;
      sz = dz < 0;
      ax = sx ? -dx : dx;
      az = sz ? -dz : dz;
      ay = 64'd131072;
      while (ax >= 64'h8000_0000 || az >= 64'h8000_0000) begin
        ax = ax >> 1; ay = ay >> 1; az = az >> 1;
      end
      m = int_sqrt(ax * ax + ay * ay + az * az);
      if (m > 0) begin
        nxo = unit_component(ax, sx, m, -32768);
        nyo = unit_component(ay, 1'b0, m, 0);
        nzo = unit_component(az, sz, m, -32768);
      end
    end
    span = model_max - model_min;
    if (span > 64'sd2147483647) span = 64'sd2147483647;
    if (span < 0) span = 0;
    rs.height = h[31:0];
    rs.span = span[30:0];
    rs.nx = nxo[15:0];
    rs.ny = nyo[14:0];
    rs.nz = nzo[15:0];
    expected_rsp = {expected_rsp, rs};
  endtask

  // Request driver.
  int gap_left = 0;
  grid_req_t cur_req;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) predict_result(cur_req);
      if (s_valid && !s_ready) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (pending_req.size() > 0) begin
        cur_req = pending_req.pop_front();
        s_tdata <= {cur_req.pixel, cur_req.row, cur_req.col};
        s_tuser <= cur_req.kind;
        s_valid <= 1'b1;
        gap_left = burst_mode ? 0 : $urandom_range(0, 4);
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Result monitor with random back-pressure.
  int stall_left = 0;
  always @(posedge clk_i) begin
    grid_rsp_t got, want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        got = m_tdata[109:0];
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_rsp.pop_front();
          if (got.height !== want.height || got.span !== want.span ||
              got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: h %h/%h span %h/%h n %h %h %h / %h %h %h (exp/act)",
                       want.height, got.height, want.span, got.span,
                       want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
          end
        end
        stall_left = burst_mode ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[heightmap_normal_engine] ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_req.size() > 0 || s_valid || expected_rsp.size() > 0)
      @(posedge clk_i);
    repeat (QUERY_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:  model_width = value[8:0];
      CFG_DEPTH:  model_depth = value[8:0];
      CFG_OFFSET: model_offset = value;
      CFG_SCALE:  model_scale = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic add_write(int c, int r, logic [7:0] pixel);
    grid_req_t rq;
    rq.kind = KIND_WRITE; rq.col = 8'(c); rq.row = 8'(r); rq.pixel = pixel;
    pending_req = {pending_req, rq};
    if (c < gen_w && r < gen_d) gen_written[r * 256 + c] = 1;
  endtask

  // Writes any neighbour the query would read that holds no height yet.
  task automatic add_query(int c, int r);
    grid_req_t rq;
    int x, z;
    x = c; z = r;
    if (x < 1) x = 1;
    if (z < 1) z = 1;
    if (x > gen_w - 2) x = gen_w - 2;
    if (z > gen_d - 2) z = gen_d - 2;
    if (!gen_written[z * 256 + x - 1]) add_write(x - 1, z, 8'($urandom_range(0, 255)));
    if (!gen_written[z * 256 + x + 1]) add_write(x + 1, z, 8'($urandom_range(0, 255)));
    if (!gen_written[(z - 1) * 256 + x]) add_write(x, z - 1, 8'($urandom_range(0, 255)));
    if (!gen_written[(z + 1) * 256 + x]) add_write(x, z + 1, 8'($urandom_range(0, 255)));
    rq.kind = KIND_QUERY; rq.col = 8'(c); rq.row = 8'(r);
    rq.pixel = 8'($urandom_range(0, 255));
    pending_req = {pending_req, rq};
  endtask

  task automatic run_phase(logic [8:0] w, logic [8:0] d, logic [31:0] off,
                           logic [31:0] sc, int n);
    int c, r;
    wait_idle();
    write_reg(CFG_WIDTH, {23'd0, w});
    write_reg(CFG_DEPTH, {23'd0, d});
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_SCALE, sc);
    gen_w = clamp_dim(w);
    gen_d = clamp_dim(d);
    burst_mode = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) burst_mode = ~burst_mode;
      if ($urandom_range(0, 9) < 2) begin
        c = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
      end else begin
        c = $urandom_range(0, gen_w - 1);
        r = $urandom_range(0, gen_d - 1);
      end
      if ($urandom_range(0, 99) < (gen_w > 32 ? 25 : 50)) add_query(c, r);
      else add_write(c, r, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed part on the reset configuration.
    add_write(0, 0, 8'd0);
    add_write(255, 255, 8'd255);
    add_write(128, 64, 8'd128);
    add_write(1, 1, 8'd127);
    add_query(0, 0);
    add_query(255, 255);
    add_query(0, 255);
    add_query(1, 1);
    add_query(128, 64);
    // Dimensions below, inside and above the legal range, with extreme, random and zero offset and scale.
    run_phase(9'd0, 9'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 200);
    run_phase(9'd5, 9'd7, 32'h8000_0000, 32'h8000_0000, 200);
    run_phase(9'd511, 9'd300, $urandom, $urandom, 100);
    run_phase(9'd8, 9'd6, $urandom_range(0, 32'h0003_0000) - 32'h0001_8000,
              $urandom_range(0, 32'h0040_0000), 300);
    run_phase(9'd2, 9'd4, 32'h0, 32'h0, 150);
    run_phase(9'd3, 9'd3, $urandom, 32'hFFFF_0000, 150);
    run_phase(9'd12, 9'd10, 32'h0000_8000, $urandom_range(0, 32'h0100_0000), 320);
    wait_idle();
    if (mismatches == 0) begin
      $display("[heightmap_normal_engine] OK");
    end else begin
      $display("[heightmap_normal_engine] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/hne_pkg.sv
rtl/core/heightmap_normal_engine.sv
bench/tb_heightmap_normal_engine.sv
